// ===== design/dcs_pkg.sv =====
package dcs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_PLUG  = 4'd1,
    ST_HAND  = 4'd2,
    ST_LOCK  = 4'd3,
    ST_INSUL = 4'd4,
    ST_XFER  = 4'd5,
    ST_WIND  = 4'd6,
    ST_INHIB = 4'd7,
    ST_ERR   = 4'd8
  } session_state_t;

  typedef enum logic [3:0] {
    EV_PLUG_IN  = 4'd0,
    EV_PLUG_OUT = 4'd1,
    EV_BMS      = 4'd2,
    EV_INH_ON   = 4'd3,
    EV_INH_OFF  = 4'd4,
    EV_IN1_ON   = 4'd5,
    EV_IN1_OFF  = 4'd6,
    EV_IN2_ON   = 4'd7,
    EV_CAPS     = 4'd8,
    EV_STATUS   = 4'd9
  } event_t;

  typedef enum logic [1:0] {
    LINK_KEEP    = 2'd0,
    LINK_ENABLE  = 2'd1,
    LINK_DISABLE = 2'd2
  } link_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       battery_full;
    logic       station_voltage_ok;
    logic       params_complete;
    logic       station_fault;
    logic       connector_locked;
  } in_item_t;

  typedef struct packed {
    logic [3:0] session_state;
    logic       shutdown_pulse;
    logic       go_ahead_pulse;
    logic       contactor_permit_pulse;
    logic       session_reset_pulse;
    logic       station_reset_pulse;
    logic [1:0] link_tx_cmd;
    logic       recalc_current_pulse;
    logic       recalc_time_pulse;
    logic       ramp_down_pulse;
    logic       permit_out_off_pulse;
    logic       invalid_event;
  } out_item_t;

endpackage

// ===== design/dcs_in_if.sv =====
interface dcs_in_if import dcs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dcs_out_if.sv =====
interface dcs_out_if import dcs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dc_charge_session_sequencer_core.sv =====
// An accepted event beat is held in the input register and then in the result register.
// Throughput: one event per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// The session state register is updated as each event leaves the input register.
// Reset (rst, synchronous): state returns to idle, both pipeline registers empty.
module dc_charge_session_sequencer_core import dcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dcs_in_if.sink    in_ch,
  dcs_out_if.source out_ch
);

  in_item_t       in_q;
  logic           in_vld;
  out_item_t      out_q;
  logic           out_vld;
  session_state_t state;
  session_state_t state_next;
  out_item_t      res;
  logic           adv_out;
  logic           fire;

  assign adv_out     = !out_vld || out_ch.ready;
  assign fire        = in_vld && adv_out;
  assign in_ch.ready = !in_vld || adv_out;
  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_q;

  always_comb begin
    res        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_q.op == EV_PLUG_IN) state_next = ST_PLUG;
        else if (in_q.op == EV_BMS) begin
          if (in_q.battery_full) state_next = ST_INHIB;
        end
        else if (in_q.op == EV_INH_ON) state_next = ST_INHIB;
        else res.invalid_event = 1'b1;
      end
      ST_PLUG: begin
        if (in_q.op == EV_BMS) begin
          if (in_q.battery_full) state_next = ST_INHIB;
        end
        else if (in_q.op == EV_IN1_ON) begin
          res.station_reset_pulse = 1'b1;
          res.link_tx_cmd         = LINK_ENABLE;
          state_next              = ST_HAND;
        end
        else if (in_q.op == EV_PLUG_OUT) begin
          res.session_reset_pulse = 1'b1;
          state_next              = ST_IDLE;
        end
        else if (in_q.op == EV_INH_ON) state_next = ST_INHIB;
        else res.invalid_event = 1'b1;
      end
      ST_HAND: begin
        if (in_q.op == EV_IN1_OFF) begin
          res.shutdown_pulse = 1'b1;
          state_next         = ST_PLUG;
        end
        else if (in_q.op == EV_BMS) begin
          if (in_q.battery_full) begin
            res.shutdown_pulse = 1'b1;
            state_next         = ST_INHIB;
          end
        end
        else if (in_q.op == EV_CAPS) begin
          if (!in_q.station_voltage_ok) begin
            res.shutdown_pulse = 1'b1;
            state_next         = ST_ERR;
          end
          else if (in_q.params_complete) begin
            res.go_ahead_pulse = 1'b1;
            state_next         = ST_LOCK;
          end
        end
        else if (in_q.op == EV_STATUS) begin
          // station fault wins over parameters complete
          if (in_q.station_fault) begin
            res.link_tx_cmd = LINK_DISABLE;
            state_next      = ST_ERR;
          end
          else if (in_q.params_complete) begin
            res.go_ahead_pulse = 1'b1;
            state_next         = ST_LOCK;
          end
        end
        else if (in_q.op == EV_PLUG_OUT) begin
          res.session_reset_pulse = 1'b1;
          state_next              = ST_IDLE;
        end
        else if (in_q.op == EV_INH_ON) state_next = ST_INHIB;
        else res.invalid_event = 1'b1;
      end
      ST_LOCK: begin
        if (in_q.op == EV_IN1_OFF) begin
          res.shutdown_pulse = 1'b1;
          state_next         = ST_PLUG;
        end
        else if (in_q.op == EV_BMS) begin
          if (in_q.battery_full) begin
            res.shutdown_pulse = 1'b1;
            state_next         = ST_INHIB;
          end
        end
        else if (in_q.op == EV_CAPS) begin
          // accepted, no action
        end
        else if (in_q.op == EV_STATUS) begin
          if (in_q.station_fault) begin
            res.link_tx_cmd = LINK_DISABLE;
            state_next      = ST_ERR;
          end
          else if (in_q.connector_locked) state_next = ST_INSUL;
        end
        else if (in_q.op == EV_PLUG_OUT) begin
          res.shutdown_pulse      = 1'b1;
          res.session_reset_pulse = 1'b1;
          state_next              = ST_IDLE;
        end
        else if (in_q.op == EV_INH_ON) begin
          res.permit_out_off_pulse = 1'b1;
          state_next               = ST_INHIB;
        end
        else res.invalid_event = 1'b1;
      end
      ST_INSUL: begin
        if (in_q.op == EV_IN1_OFF) begin
          res.shutdown_pulse = 1'b1;
          state_next         = ST_PLUG;
        end
        else if (in_q.op == EV_BMS) begin
          if (in_q.battery_full) begin
            res.shutdown_pulse = 1'b1;
            state_next         = ST_INHIB;
          end
        end
        else if (in_q.op == EV_IN2_ON) begin
          res.contactor_permit_pulse = 1'b1;
          state_next                 = ST_XFER;
        end
        else if (in_q.op == EV_PLUG_OUT) begin
          res.session_reset_pulse = 1'b1;
          state_next              = ST_IDLE;
        end
        else if (in_q.op == EV_INH_ON) state_next = ST_INHIB;
        else res.invalid_event = 1'b1;
      end
      ST_XFER: begin
        if (in_q.op == EV_BMS) begin
          if (in_q.battery_full) begin
            res.shutdown_pulse = 1'b1;
            state_next         = ST_WIND;
          end
          else res.recalc_current_pulse = 1'b1;
        end
        else if (in_q.op == EV_PLUG_OUT) begin
          res.session_reset_pulse = 1'b1;
          state_next              = ST_IDLE;
        end
        else if (in_q.op == EV_CAPS) begin
          res.recalc_current_pulse = 1'b1;
          res.recalc_time_pulse    = 1'b1;
        end
        else if (in_q.op == EV_STATUS) begin
          if (in_q.station_fault) begin
            res.link_tx_cmd = LINK_DISABLE;
            state_next      = ST_ERR;
          end
        end
        else if (in_q.op == EV_INH_ON) state_next = ST_INHIB;
        else res.invalid_event = 1'b1;
      end
      ST_WIND: begin
        // no exit: keep ramping down on measurement beats
        if (in_q.op == EV_BMS || in_q.op == EV_CAPS || in_q.op == EV_STATUS)
          res.ramp_down_pulse = 1'b1;
        else if (in_q.op == EV_PLUG_OUT || in_q.op == EV_INH_ON) begin
          // accepted, no action
        end
        else res.invalid_event = 1'b1;
      end
      ST_INHIB: begin
        if (in_q.op != EV_BMS && in_q.op != EV_INH_OFF) res.invalid_event = 1'b1;
      end
      ST_ERR: begin
        if (in_q.op == EV_BMS) begin
          // accepted, no action
        end
        else if (in_q.op == EV_PLUG_OUT) begin
          res.session_reset_pulse = 1'b1;
          state_next              = ST_IDLE;
        end
        else res.invalid_event = 1'b1;
      end
      default: res.invalid_event = 1'b1;
    endcase
    res.session_state = state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      state   <= ST_IDLE;
    end else begin
      if (in_ch.ready) in_vld <= in_ch.valid;
      if (adv_out) out_vld <= in_vld;
      if (fire) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_q <= in_ch.data;
    if (fire) out_q <= res;
  end

`ifndef SYNTHESIS
  a_state_tracks_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> (out_q.session_state == state))
    else $error("result state differs from session state register");

  a_invalid_is_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_q.invalid_event) |->
      (!out_q.shutdown_pulse && !out_q.go_ahead_pulse && !out_q.contactor_permit_pulse &&
       !out_q.session_reset_pulse && !out_q.station_reset_pulse &&
       out_q.link_tx_cmd == LINK_KEEP && !out_q.recalc_current_pulse &&
       !out_q.recalc_time_pulse && !out_q.ramp_down_pulse && !out_q.permit_out_off_pulse))
    else $error("rejected event carries an action");

  a_contactor_into_xfer: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_q.contactor_permit_pulse) |-> (out_q.session_state == ST_XFER))
    else $error("contactor permit outside entry to energy transfer");

  a_go_ahead_into_lock: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_q.go_ahead_pulse) |-> (out_q.session_state == ST_LOCK))
    else $error("go-ahead outside entry to connector lock");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (in_vld && out_vld && !out_ch.ready))
    else $error("input stalled while pipeline can advance");
`endif

endmodule

// ===== test/tb_dc_charge_session_sequencer_core.sv =====
`timescale 1ns / 100ps

module tb_dc_charge_session_sequencer_core import dcs_pkg::*; ();

  localparam int RESET_CYCLES    = 7;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_LIMIT     = 1000;
  localparam int IN_W            = $bits(in_item_t);

  // Event codes outside the defined set
  localparam logic [3:0] EV_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] EV_UNKNOWN_HI = 4'd15;

  // Condition flags in item order: full, voltage ok, params, fault, locked
  localparam logic [4:0] F_NONE   = 5'b00000;
  localparam logic [4:0] F_FULL   = 5'b10000;
  localparam logic [4:0] F_VOLT   = 5'b01000;
  localparam logic [4:0] F_PARAMS = 5'b00100;
  localparam logic [4:0] F_FAULT  = 5'b00010;
  localparam logic [4:0] F_LOCKED = 5'b00001;
  localparam logic [4:0] F_ALL    = 5'b11111;

  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  dcs_in_if  in_ch ();
  dcs_out_if out_ch ();

  dc_charge_session_sequencer_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  stim_row_t      script[$];
  out_item_t      expected_q[$];
  session_state_t model_state;
  int             mismatches = 0;
  int             src_idle_pct = 0;
  int             sink_stall_pct = 0;
  int             idle_cycles = 0;
  // toggle to ask the result side for one long hold-off
  bit             hold_req = 1'b0;

  // Next state and action pulses for one event
  function automatic out_item_t session_step(input session_state_t cur, input in_item_t ev,
                                             output session_state_t nxt);
    out_item_t r;
    r   = '0;
    nxt = cur;
    case (cur)
      ST_IDLE: begin
        case (ev.op)
          EV_PLUG_IN: nxt = ST_PLUG;
          EV_BMS:     if (ev.battery_full) nxt = ST_INHIB;
          EV_INH_ON:  nxt = ST_INHIB;
          default:    r.invalid_event = 1'b1;
        endcase
      end
      ST_PLUG: begin
        case (ev.op)
          EV_BMS: if (ev.battery_full) nxt = ST_INHIB;
          EV_IN1_ON: begin
            r.station_reset_pulse = 1'b1;
            r.link_tx_cmd         = LINK_ENABLE;
            nxt                   = ST_HAND;
          end
          EV_PLUG_OUT: begin
            r.session_reset_pulse = 1'b1;
            nxt                   = ST_IDLE;
          end
          EV_INH_ON: nxt = ST_INHIB;
          default:   r.invalid_event = 1'b1;
        endcase
      end
      ST_HAND: begin
        case (ev.op)
          EV_IN1_OFF: begin
            r.shutdown_pulse = 1'b1;
            nxt              = ST_PLUG;
          end
          EV_BMS: begin
            if (ev.battery_full) begin
              r.shutdown_pulse = 1'b1;
              nxt              = ST_INHIB;
            end
          end
          EV_CAPS: begin
            if (!ev.station_voltage_ok) begin
              r.shutdown_pulse = 1'b1;
              nxt              = ST_ERR;
            end else if (ev.params_complete) begin
              r.go_ahead_pulse = 1'b1;
              nxt              = ST_LOCK;
            end
          end
          EV_STATUS: begin
            // station fault wins over parameters complete
            if (ev.station_fault) begin
              r.link_tx_cmd = LINK_DISABLE;
              nxt           = ST_ERR;
            end else if (ev.params_complete) begin
              r.go_ahead_pulse = 1'b1;
              nxt              = ST_LOCK;
            end
          end
          EV_PLUG_OUT: begin
            r.session_reset_pulse = 1'b1;
            nxt                   = ST_IDLE;
          end
          EV_INH_ON: nxt = ST_INHIB;
          default:   r.invalid_event = 1'b1;
        endcase
      end
      ST_LOCK: begin
        case (ev.op)
          EV_IN1_OFF: begin
            r.shutdown_pulse = 1'b1;
            nxt              = ST_PLUG;
          end
          EV_BMS: begin
            if (ev.battery_full) begin
              r.shutdown_pulse = 1'b1;
              nxt              = ST_INHIB;
            end
          end
          EV_CAPS: ;
          EV_STATUS: begin
            if (ev.station_fault) begin
              r.link_tx_cmd = LINK_DISABLE;
              nxt           = ST_ERR;
            end else if (ev.connector_locked) begin
              nxt = ST_INSUL;
            end
          end
          EV_PLUG_OUT: begin
            r.shutdown_pulse      = 1'b1;
            r.session_reset_pulse = 1'b1;
            nxt                   = ST_IDLE;
          end
          EV_INH_ON: begin
            r.permit_out_off_pulse = 1'b1;
            nxt                    = ST_INHIB;
          end
          default: r.invalid_event = 1'b1;
        endcase
      end
      ST_INSUL: begin
        case (ev.op)
          EV_IN1_OFF: begin
            r.shutdown_pulse = 1'b1;
            nxt              = ST_PLUG;
          end
          EV_BMS: begin
            if (ev.battery_full) begin
              r.shutdown_pulse = 1'b1;
              nxt              = ST_INHIB;
            end
          end
          EV_IN2_ON: begin
            r.contactor_permit_pulse = 1'b1;
            nxt                      = ST_XFER;
          end
          EV_PLUG_OUT: begin
            r.session_reset_pulse = 1'b1;
            nxt                   = ST_IDLE;
          end
          EV_INH_ON: nxt = ST_INHIB;
          default:   r.invalid_event = 1'b1;
        endcase
      end
      ST_XFER: begin
        case (ev.op)
          EV_BMS: begin
            if (ev.battery_full) begin
              r.shutdown_pulse = 1'b1;
              nxt              = ST_WIND;
            end else begin
              r.recalc_current_pulse = 1'b1;
            end
          end
          EV_PLUG_OUT: begin
            r.session_reset_pulse = 1'b1;
            nxt                   = ST_IDLE;
          end
          EV_CAPS: begin
            r.recalc_current_pulse = 1'b1;
            r.recalc_time_pulse    = 1'b1;
          end
          EV_STATUS: begin
            if (ev.station_fault) begin
              r.link_tx_cmd = LINK_DISABLE;
              nxt           = ST_ERR;
            end
          end
          EV_INH_ON: nxt = ST_INHIB;
          default:   r.invalid_event = 1'b1;
        endcase
      end
      ST_WIND: begin
        case (ev.op)
          EV_BMS, EV_CAPS, EV_STATUS: r.ramp_down_pulse = 1'b1;
          EV_PLUG_OUT, EV_INH_ON: ;
          default: r.invalid_event = 1'b1;
        endcase
      end
      ST_INHIB: begin
        case (ev.op)
          EV_BMS, EV_INH_OFF: ;
          default: r.invalid_event = 1'b1;
        endcase
      end
      ST_ERR: begin
        case (ev.op)
          EV_BMS: ;
          EV_PLUG_OUT: begin
            r.session_reset_pulse = 1'b1;
            nxt                   = ST_IDLE;
          end
          default: r.invalid_event = 1'b1;
        endcase
      end
      default: r.invalid_event = 1'b1;
    endcase
    r.session_state = nxt;
    return r;
  endfunction

  function automatic out_item_t quiet(input session_state_t s, input logic inv);
    out_item_t r;
    r               = '0;
    r.session_state = s;
    r.invalid_event = inv;
    return r;
  endfunction

  // Mostly the event that moves the session on, with random flags; a quarter is noise
  function automatic in_item_t pick_event(input session_state_t cur);
    in_item_t it;
    it = IN_W'($urandom);
    if ($urandom_range(99) < 25) return it;
    case (cur)
      ST_IDLE: it.op = EV_PLUG_IN;
      ST_PLUG: it.op = EV_IN1_ON;
      ST_HAND: begin
        it.op                 = $urandom_range(1) ? EV_STATUS : EV_CAPS;
        it.station_fault      = ($urandom_range(9) == 0);
        it.station_voltage_ok = ($urandom_range(9) != 0);
        it.params_complete    = ($urandom_range(3) != 0);
      end
      ST_LOCK: begin
        it.op               = EV_STATUS;
        it.station_fault    = ($urandom_range(9) == 0);
        it.connector_locked = ($urandom_range(3) != 0);
      end
      ST_INSUL: it.op = EV_IN2_ON;
      ST_XFER: begin
        case ($urandom_range(9))
          0:       it.op = EV_PLUG_OUT;
          1, 2, 3: it.op = EV_CAPS;
          4, 5, 6: it.op = EV_BMS;
          default: it.op = EV_STATUS;
        endcase
        it.station_fault = ($urandom_range(9) == 0);
      end
      ST_ERR:  it.op = EV_PLUG_OUT;
      default: it.op = EV_BMS;
    endcase
    // drop back to the start now and then
    if ($urandom_range(19) == 0) it.op = EV_PLUG_OUT;
    return it;
  endfunction

  task automatic add_row(input logic [3:0] op, input logic [4:0] flags,
                         input bit typed = 1'b0, input out_item_t want = '0);
    stim_row_t row;
    row.ev    = {op, flags};
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endtask

  task automatic send_event(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t      pred;
    session_state_t nxt;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= IN_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pred        = session_step(model_state, it, nxt);
    model_state = nxt;
    expected_q.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Keep out of wind-down and inhibited unless allowed: neither has an exit
  task automatic run_random(input int n, input bit allow_terminal);
    in_item_t       it;
    out_item_t      probe;
    session_state_t nxt;
    repeat (n) begin
      do begin
        it    = pick_event(model_state);
        probe = session_step(model_state, it, nxt);
      end while (!allow_terminal && (nxt == ST_WIND || nxt == ST_INHIB));
      send_event(it, 1'b0, probe);
    end
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("session_state", want.session_state, got.session_state);
        check_field("shutdown_pulse", want.shutdown_pulse, got.shutdown_pulse);
        check_field("go_ahead_pulse", want.go_ahead_pulse, got.go_ahead_pulse);
        check_field("contactor_permit_pulse", want.contactor_permit_pulse,
                    got.contactor_permit_pulse);
        check_field("session_reset_pulse", want.session_reset_pulse, got.session_reset_pulse);
        check_field("station_reset_pulse", want.station_reset_pulse, got.station_reset_pulse);
        check_field("link_tx_cmd", want.link_tx_cmd, got.link_tx_cmd);
        check_field("recalc_current_pulse", want.recalc_current_pulse,
                    got.recalc_current_pulse);
        check_field("recalc_time_pulse", want.recalc_time_pulse, got.recalc_time_pulse);
        check_field("ramp_down_pulse", want.ramp_down_pulse, got.ramp_down_pulse);
        check_field("permit_out_off_pulse", want.permit_out_off_pulse,
                    got.permit_out_off_pulse);
        check_field("invalid_event", want.invalid_event, got.invalid_event);
      end
    end
  end

  // Stall watchdog: any beat on either side restarts the count
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_dc_charge_session_sequencer_core failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    bit hold_seen;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin : stimulus
    out_item_t err_entry;
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    model_state = ST_IDLE;

    err_entry             = quiet(ST_ERR, 1'b0);
    err_entry.link_tx_cmd = LINK_DISABLE;

    add_row(EV_UNKNOWN_HI, F_ALL, 1'b1, quiet(ST_IDLE, 1'b1));
    add_row(EV_PLUG_OUT, F_NONE, 1'b1, quiet(ST_IDLE, 1'b1));
    add_row(EV_BMS, F_ALL & ~F_FULL, 1'b1, quiet(ST_IDLE, 1'b0));
    add_row(EV_PLUG_IN, F_NONE);
    add_row(EV_IN1_ON, F_NONE);
    add_row(EV_IN1_OFF, F_ALL & ~F_FULL);
    add_row(EV_IN1_ON, F_NONE);
    add_row(EV_STATUS, F_PARAMS | F_FAULT | F_LOCKED, 1'b1, err_entry);
    add_row(EV_BMS, F_NONE, 1'b1, quiet(ST_ERR, 1'b0));
    add_row(EV_IN2_ON, F_ALL, 1'b1, quiet(ST_ERR, 1'b1));
    add_row(EV_PLUG_OUT, F_NONE);
    add_row(EV_PLUG_IN, F_NONE);
    add_row(EV_IN1_ON, F_NONE);
    add_row(EV_CAPS, F_VOLT);
    add_row(EV_STATUS, F_PARAMS);
    add_row(EV_STATUS, F_NONE);
    add_row(EV_STATUS, F_LOCKED);
    add_row(EV_IN2_ON, F_NONE);
    add_row(EV_CAPS, F_VOLT);
    add_row(EV_BMS, F_NONE);
    add_row(EV_STATUS, F_PARAMS | F_LOCKED);
    add_row(EV_UNKNOWN_LO, F_NONE, 1'b1, quiet(ST_XFER, 1'b1));
    add_row(EV_PLUG_OUT, F_NONE);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);
    wait_drained();

    // hold the result side off while events keep coming
    hold_req = ~hold_req;
    run_random(30, 1'b0);
    wait_drained();

    run_random(120, 1'b0);
    src_idle_pct = 65;
    run_random(130, 1'b0);
    wait_drained();
    src_idle_pct   = 0;
    sink_stall_pct = 65;
    run_random(130, 1'b0);
    src_idle_pct   = 7;
    sink_stall_pct = 7;
    run_random(120, 1'b0);

    // last phase may end up in wind-down or inhibited for good
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_random(120, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_dc_charge_session_sequencer_core passed");
    end else begin
      $display("tb_dc_charge_session_sequencer_core failed");
    end
    $finish;
  end

endmodule
